// ===== rtl/alfs_pkg.sv =====
// Shared types, constants and codes for the addressable LED frame serializer.
package alfs_pkg;

    localparam int MAX_PIXELS_DEFAULT = 256;

    localparam logic [7:0] GREEN_SCALE = 8'hB0;
    localparam logic [7:0] BLUE_SCALE  = 8'hF0;

    localparam logic [7:0] LOW_DUTY_RESET    = 8'd30;
    localparam logic       FOUR_BYTE_RESET   = 1'b0;
    localparam logic [8:0] PIXEL_COUNT_RESET = 9'd256;
    localparam logic [3:0] GAP_PIXELS_RESET  = 4'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_DUTY    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOUR_BYTE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_COUNT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_PIXELS  = 2'd3;

    localparam logic [1:0] KIND_SET_PIXEL = 2'd0;
    localparam logic [1:0] KIND_SET_ALL   = 2'd1;
    localparam logic [1:0] KIND_RENDER    = 2'd2;
    localparam logic [1:0] KIND_TICK      = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
    localparam logic [1:0] STATUS_ABORTED   = 2'd2;

    localparam logic [5:0] BITS_3BYTE = 6'd24;
    localparam logic [5:0] BITS_4BYTE = 6'd32;

    typedef struct packed {
        logic [7:0] low_duty;
        logic       four_byte_mode;
        logic [8:0] pixel_count;
        logic [3:0] gap_pixels;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_TICK
    } ctrl_state_t;

endpackage

// ===== rtl/addressable_led_frame_serializer_top.sv =====
// Top level of the addressable LED frame serializer.
//
// Input channel (s_valid/s_ready) takes one word per item: set pixel, set all,
// render, or bit-slot tick. Output channel (m_valid/m_ready) returns exactly one
// word per item: duty, slot_active, frame_done and status.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata), written
// while no item is in flight.
// Result path: result is registered in the cycle after accept; a data-bit tick
// first reads the pixel RAM (registered read data) and loads it in ST_TICK.
// Throughput: one item per cycle while output is free or draining; data ticks
// stall in ST_TICK; set all writes all MAX_PIXELS entries with s_ready low.
// Reset: configuration returns to defaults, the frame stops, and a clearing pass
// writes zero to all MAX_PIXELS entries; s_ready stays low until it ends.
// A stalled receiver holds the result in the output register; one new item is
// taken in the cycle the held word leaves.
module addressable_led_frame_serializer_top #(
    parameter int MAX_PIXELS = alfs_pkg::MAX_PIXELS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [alfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [alfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_kind,
    input  logic [7:0]                        s_pixel_index,
    input  logic [7:0]                        s_red,
    input  logic [7:0]                        s_green,
    input  logic [7:0]                        s_blue,
    input  logic [7:0]                        s_white,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [8:0]                        m_duty,
    output logic                              m_slot_active,
    output logic                              m_frame_done,
    output logic [1:0]                        m_status
);
    import alfs_pkg::*;

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    cfg_t          cfg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;

    alfs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    alfs_pixel_ram #(
        .DEPTH  (MAX_PIXELS),
        .ADDR_W (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    alfs_ctrl #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_pixel_index (s_pixel_index),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_white       (s_white),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_duty        (m_duty),
        .m_slot_active (m_slot_active),
        .m_frame_done  (m_frame_done),
        .m_status      (m_status),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    // new word only when the output register is free or draining
    a_ready_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid || m_ready))
        else $error("input accepted while result register is blocked");

    a_done_is_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_done) |-> m_slot_active)
        else $error("frame_done outside a frame slot");

    a_status_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STATUS_OK) |-> (m_duty == 9'd0 && !m_slot_active))
        else $error("error status carries slot data");

    a_duty_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_duty != 9'd0) |-> m_slot_active)
        else $error("nonzero duty outside a frame");

    a_no_ram_conflict: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> !wr_en)
        else $error("pixel RAM read and written in the same cycle");

endmodule

// ===== rtl/alfs_cfg_regs.sv =====
// Configuration register bank of the LED frame serializer.
module alfs_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [alfs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [alfs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output alfs_pkg::cfg_t                     cfg
);
    import alfs_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_duty       <= LOW_DUTY_RESET;
            cfg_reg.four_byte_mode <= FOUR_BYTE_RESET;
            cfg_reg.pixel_count    <= PIXEL_COUNT_RESET;
            cfg_reg.gap_pixels     <= GAP_PIXELS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_LOW_DUTY:    cfg_reg.low_duty       <= cfg_wdata[7:0];
                CFG_FOUR_BYTE:   cfg_reg.four_byte_mode <= cfg_wdata[0];
                CFG_PIXEL_COUNT: cfg_reg.pixel_count    <= cfg_wdata[8:0];
                CFG_GAP_PIXELS:  cfg_reg.gap_pixels     <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/alfs_pixel_ram.sv =====
// Pixel store: one write port, one read port with registered read data.
module alfs_pixel_ram #(
    parameter int DEPTH  = alfs_pkg::MAX_PIXELS_DEFAULT,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [31:0]       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]       rd_data
);
    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/alfs_ctrl.sv =====
// Item sequencer: store updates, fill sweeps, frame counters and result register.
module alfs_ctrl #(
    parameter int MAX_PIXELS = alfs_pkg::MAX_PIXELS_DEFAULT,
    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  alfs_pkg::cfg_t cfg,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [1:0]     s_kind,
    input  logic [7:0]     s_pixel_index,
    input  logic [7:0]     s_red,
    input  logic [7:0]     s_green,
    input  logic [7:0]     s_blue,
    input  logic [7:0]     s_white,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [8:0]     m_duty,
    output logic           m_slot_active,
    output logic           m_frame_done,
    output logic [1:0]     m_status,
    output logic           wr_en,
    output logic [AW-1:0]  wr_addr,
    output logic [31:0]    wr_data,
    output logic           rd_en,
    output logic [AW-1:0]  rd_addr,
    input  logic [31:0]    rd_data
);
    import alfs_pkg::*;

    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int EW = (CW > 9) ? CW : 9;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PIXELS - 1);

    ctrl_state_t state_reg, state_next;

    logic [AW-1:0] fill_addr_reg, fill_addr_next;
    logic [31:0]   fill_word_reg, fill_word_next;
    logic          busy_reg, busy_next;
    logic [CW-1:0] pix_pos_reg, pix_pos_next;
    logic [4:0]    bit_pos_reg, bit_pos_next;
    logic [8:0]    gap_cnt_reg, gap_cnt_next;

    logic       m_valid_reg;
    logic [8:0] m_duty_reg, duty_next;
    logic       m_active_reg, active_next;
    logic       m_done_reg, done_next;
    logic [1:0] m_status_reg, status_next;
    logic       out_load;

    logic          accept;
    logic          fill_last;
    logic [EW-1:0] pc_ext;
    logic [CW-1:0] count_eff;
    logic [5:0]    bpp;
    logic [8:0]    gap_total;
    logic          tick_hit;
    logic [15:0]   green_prod;
    logic [15:0]   blue_prod;
    logic [31:0]   word_new;
    logic          bit_sel;
    logic [CW-1:0] pix_new;
    logic [5:0]    bit_inc;

    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign fill_last = (fill_addr_reg == LAST_ADDR);

    assign pc_ext = EW'(cfg.pixel_count);
    always_comb begin
        if (cfg.pixel_count == 9'd0) begin
            count_eff = CW'(1);
        end else if (pc_ext > EW'(MAX_PIXELS)) begin
            count_eff = CW'(MAX_PIXELS);
        end else begin
            count_eff = pc_ext[CW-1:0];
        end
    end

    assign bpp       = cfg.four_byte_mode ? BITS_4BYTE : BITS_3BYTE;
    assign gap_total = cfg.four_byte_mode ? 9'({cfg.gap_pixels, 5'b0})
                     : 9'({cfg.gap_pixels, 4'b0}) + 9'({cfg.gap_pixels, 3'b0});
    assign tick_hit  = busy_reg && (pix_pos_reg < count_eff);

    assign green_prod = 16'(s_green) * 16'(GREEN_SCALE);
    assign blue_prod  = 16'(s_blue) * 16'(BLUE_SCALE);
    assign word_new   = {green_prod[15:8], s_red, blue_prod[15:8],
                         cfg.four_byte_mode ? s_white : 8'd0};

    assign bit_sel = rd_data[~bit_pos_reg];
    assign bit_inc = {1'b0, bit_pos_reg} + 6'd1;
    assign pix_new = (bit_inc >= bpp) ? pix_pos_reg + CW'(1) : pix_pos_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (fill_last) state_next = ST_IDLE;
            ST_FILL:  if (fill_last) state_next = ST_IDLE;
            ST_TICK:  state_next = ST_IDLE;
            ST_IDLE: begin
                if (accept && s_kind == KIND_SET_ALL) begin
                    state_next = ST_FILL;
                end else if (accept && s_kind == KIND_TICK && tick_hit) begin
                    state_next = ST_TICK;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        wr_en          = 1'b0;
        wr_addr        = fill_addr_reg;
        wr_data        = fill_word_reg;
        rd_en          = 1'b0;
        rd_addr        = pix_pos_reg[AW-1:0];
        fill_addr_next = fill_addr_reg;
        fill_word_next = fill_word_reg;
        busy_next      = busy_reg;
        pix_pos_next   = pix_pos_reg;
        bit_pos_next   = bit_pos_reg;
        gap_cnt_next   = gap_cnt_reg;
        out_load       = 1'b0;
        duty_next      = 9'd0;
        active_next    = 1'b0;
        done_next      = 1'b0;
        status_next    = STATUS_OK;

        unique case (state_reg)
            ST_CLEAR, ST_FILL: begin
                wr_en          = 1'b1;
                wr_data        = (state_reg == ST_CLEAR) ? 32'd0 : fill_word_reg;
                fill_addr_next = fill_last ? '0 : fill_addr_reg + AW'(1);
            end
            ST_TICK: begin
                out_load     = 1'b1;
                active_next  = 1'b1;
                duty_next    = bit_sel ? {cfg.low_duty, 1'b0} : {1'b0, cfg.low_duty};
                pix_pos_next = pix_new;
                bit_pos_next = (bit_inc >= bpp) ? 5'd0 : bit_inc[4:0];
                if (pix_new >= count_eff && cfg.gap_pixels == 4'd0) begin
                    done_next    = 1'b1;
                    busy_next    = 1'b0;
                    pix_pos_next = '0;
                    bit_pos_next = 5'd0;
                    gap_cnt_next = 9'd0;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_kind)
                        KIND_SET_PIXEL: begin
                            out_load = 1'b1;
                            if (EW'(s_pixel_index) < EW'(count_eff)) begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(s_pixel_index);
                                wr_data = word_new;
                            end else begin
                                status_next = STATUS_BAD_INDEX;
                            end
                        end
                        KIND_SET_ALL: begin
                            out_load       = 1'b1;
                            fill_word_next = word_new;
                        end
                        KIND_RENDER: begin
                            out_load     = 1'b1;
                            busy_next    = !busy_reg;
                            pix_pos_next = '0;
                            bit_pos_next = 5'd0;
                            gap_cnt_next = 9'd0;
                            if (busy_reg) status_next = STATUS_ABORTED;
                        end
                        KIND_TICK: begin
                            if (tick_hit) begin
                                rd_en = 1'b1;
                            end else begin
                                out_load    = 1'b1;
                                active_next = busy_reg;
                                if (busy_reg) begin
                                    if ({1'b0, gap_cnt_reg} + 10'd1 >= {1'b0, gap_total}) begin
                                        done_next    = 1'b1;
                                        busy_next    = 1'b0;
                                        pix_pos_next = '0;
                                        bit_pos_next = 5'd0;
                                        gap_cnt_next = 9'd0;
                                    end else begin
                                        gap_cnt_next = gap_cnt_reg + 9'd1;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            fill_addr_reg <= '0;
            busy_reg      <= 1'b0;
            pix_pos_reg   <= '0;
            bit_pos_reg   <= 5'd0;
            gap_cnt_reg   <= 9'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_addr_reg <= fill_addr_next;
            busy_reg      <= busy_next;
            pix_pos_reg   <= pix_pos_next;
            bit_pos_reg   <= bit_pos_next;
            gap_cnt_reg   <= gap_cnt_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        fill_word_reg <= fill_word_next;
        if (out_load) begin
            m_duty_reg   <= duty_next;
            m_active_reg <= active_next;
            m_done_reg   <= done_next;
            m_status_reg <= status_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_duty        = m_duty_reg;
    assign m_slot_active = m_active_reg;
    assign m_frame_done  = m_done_reg;
    assign m_status      = m_status_reg;

endmodule
